[rtl/core/idp_pkg.sv]
// Shared widths, limits and control types for the int4 dequantise dot product.
package idp_pkg;

	// Field widths
	localparam int NibW   = 4;
	localparam int ActW   = 16;
	localparam int CoefW  = 16;
	localparam int ByteW  = 8;

	// Dequantised weight: 15 * -2^15 + offset stays within 21 signed bits
	localparam int WeightW = 21;
	// Weight times Q8.8 activation
	localparam int ProdW   = WeightW + ActW;
	// Accumulator and the headroom used before clamping
	localparam int AccW    = 48;
	localparam int SumW    = AccW + 2;

	localparam logic signed [AccW-1:0] AccMax = {1'b0, {(AccW-1){1'b1}}};
	localparam logic signed [AccW-1:0] AccMin = {1'b1, {(AccW-1){1'b0}}};

	typedef logic signed [WeightW-1:0] weight_t;
	typedef logic signed [ProdW-1:0]   prod_t;
	typedef logic signed [AccW-1:0]    acc_t;
	typedef logic signed [SumW-1:0]    sum_t;

	// Control that travels alongside the lane data
	typedef struct packed {
		logic valid;
		logic last;
	} ctl_t;

endpackage

[rtl/core/idp_lane.sv]
// One lane: dequantise a nibble, then multiply by its activation.
module idp_lane (
	input  logic                              clk,
	input  logic                              en,
	input  logic [idp_pkg::NibW-1:0]          q,
	input  logic signed [idp_pkg::ActW-1:0]   act,
	input  logic signed [idp_pkg::CoefW-1:0]  scale,
	input  logic signed [idp_pkg::CoefW-1:0]  offset,
	output idp_pkg::prod_t                    product
);

	idp_pkg::weight_t q_x;
	idp_pkg::weight_t scale_x;
	idp_pkg::weight_t offset_x;
	idp_pkg::weight_t w_d;
	idp_pkg::weight_t w_s1;
	logic signed [idp_pkg::ActW-1:0] act_s1;
	idp_pkg::prod_t   prod_s2;

	// Widen operands; the true weight fits, so the truncated arithmetic is exact
	assign q_x      = {{(idp_pkg::WeightW-idp_pkg::NibW){1'b0}}, q};
	assign scale_x  = {{(idp_pkg::WeightW-idp_pkg::CoefW){scale[idp_pkg::CoefW-1]}}, scale};
	assign offset_x = {{(idp_pkg::WeightW-idp_pkg::CoefW){offset[idp_pkg::CoefW-1]}}, offset};
	assign w_d      = q_x * scale_x + offset_x;

	// Stage 1: hold the dequantised weight and its activation
	always_ff @(posedge clk) begin
		if (en) begin
			w_s1   <= w_d;
			act_s1 <= act;
		end
	end

	// Stage 2: hold the 21 x 16 product
	always_ff @(posedge clk) begin
		if (en) begin
			prod_s2 <= w_s1 * act_s1;
		end
	end

	assign product = prod_s2;

endmodule

[rtl/core/idp_merge.sv]
// Merge stage: add both lane products into the accumulator, clamp, emit on last.
module idp_merge (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  idp_pkg::ctl_t        ctl,
	input  idp_pkg::prod_t       prod_even,
	input  idp_pkg::prod_t       prod_odd,
	output logic                 out_valid,
	output idp_pkg::acc_t        dot_product
);

	idp_pkg::acc_t acc_q;
	idp_pkg::acc_t out_q;
	logic          out_valid_q;
	idp_pkg::sum_t sum_d;
	idp_pkg::acc_t sat_d;
	logic          ovf_d;

	// Sum with two bits of headroom
	assign sum_d = {{(idp_pkg::SumW-idp_pkg::AccW){acc_q[idp_pkg::AccW-1]}}, acc_q}
		+ {{(idp_pkg::SumW-idp_pkg::ProdW){prod_even[idp_pkg::ProdW-1]}}, prod_even}
		+ {{(idp_pkg::SumW-idp_pkg::ProdW){prod_odd[idp_pkg::ProdW-1]}}, prod_odd};

	// Clamp when the headroom bits disagree with the 48-bit sign
	assign ovf_d = (sum_d[idp_pkg::SumW-1:idp_pkg::AccW-1] != '0) &&
		(sum_d[idp_pkg::SumW-1:idp_pkg::AccW-1] != '1);

	always_comb begin
		if (ovf_d) begin
			sat_d = sum_d[idp_pkg::SumW-1] ? idp_pkg::AccMin : idp_pkg::AccMax;
		end else begin
			sat_d = sum_d[idp_pkg::AccW-1:0];
		end
	end

	// Advance the accumulator; clear it once a dot product leaves
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (en && ctl.valid) begin
			acc_q <= ctl.last ? '0 : sat_d;
		end
	end

	// Output register: load on last, drop when the beat is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= ctl.valid && ctl.last;
		end
	end

	always_ff @(posedge clk) begin
		if (en && ctl.valid && ctl.last) begin
			out_q <= sat_d;
		end
	end

	assign out_valid   = out_valid_q;
	assign dot_product = out_q;

`ifndef SYNTHESIS
	a_acc_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(en && ctl.valid && ctl.last) |=> (acc_q == '0))
		else $error("accumulator not cleared after a last beat");

	a_acc_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(en && ctl.valid) |=> $stable(acc_q))
		else $error("accumulator moved without an item");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		(en && !(ctl.valid && ctl.last)) |=> !out_valid_q)
		else $error("result beat without a last item");
`endif

endmodule

[rtl/core/int4_dequant_dot_product.sv]
// Top level of the int4 group dequantise dot product: two lanes and a merge stage.
//
//  channel | direction | handshake            | payload
//  in      | input     | in_valid / in_ready  | weight_byte, activation_even,
//          |           |                      | activation_odd, group_scale,
//          |           |                      | group_offset, last_of_dot
//  out     | output    | out_valid/out_ready  | dot_product
//
// One input beat per cycle while the output is free or being taken.
// A last beat reaches dot_product through three register stages
// (dequantise, multiply, accumulate), all advancing together.
// When a result waits on out_ready the whole pipeline holds.
// arst_n clears the accumulator and all valid flags.
module int4_dequant_dot_product (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [idp_pkg::ByteW-1:0]          weight_byte,
	input  logic signed [idp_pkg::ActW-1:0]    activation_even,
	input  logic signed [idp_pkg::ActW-1:0]    activation_odd,
	input  logic signed [idp_pkg::CoefW-1:0]   group_scale,
	input  logic signed [idp_pkg::CoefW-1:0]   group_offset,
	input  logic                               last_of_dot,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [idp_pkg::AccW-1:0]    dot_product
);

	logic           en;
	idp_pkg::ctl_t  ctl_s1;
	idp_pkg::ctl_t  ctl_s2;
	idp_pkg::prod_t prod_even;
	idp_pkg::prod_t prod_odd;

	// Advance every stage unless a result is held at the output
	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	// Carry valid and last alongside the lane stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
		end else if (en) begin
			ctl_s1 <= '{valid: in_valid, last: last_of_dot};
			ctl_s2 <= ctl_s1;
		end
	end

	// Low nibble lane
	idp_lane u_lane_even (
		.clk    (clk),
		.en     (en),
		.q      (weight_byte[idp_pkg::NibW-1:0]),
		.act    (activation_even),
		.scale  (group_scale),
		.offset (group_offset),
		.product(prod_even)
	);

	// High nibble lane
	idp_lane u_lane_odd (
		.clk    (clk),
		.en     (en),
		.q      (weight_byte[idp_pkg::ByteW-1:idp_pkg::NibW]),
		.act    (activation_odd),
		.scale  (group_scale),
		.offset (group_offset),
		.product(prod_odd)
	);

	idp_merge u_merge (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.ctl        (ctl_s2),
		.prod_even  (prod_even),
		.prod_odd   (prod_odd),
		.out_valid  (out_valid),
		.dot_product(dot_product)
	);

endmodule
